// ----- sv/zda_pkg.sv -----
// ZDA time sentence parser: shared types, constants and helper functions.
// No dependencies; used by the core and its checker.
package zda_pkg;

  localparam int unsigned MaxBodyBytes = 256;
  localparam int unsigned LenW = 9;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CSUM    = 2'd1,
    ST_FORMAT  = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_A      = 8'h41;

  // raw sentence fields latched at end of line
  typedef struct packed {
    status_t     status;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [7:0]  rx_csum;
    logic [7:0]  calc_csum;
  } raw_t;

  function automatic logic [7:0] hdr_char(input logic [4:0] idx);
    logic [7:0] c;
    begin
      case (idx)
        5'd0:    c = CH_G;
        5'd2:    c = CH_Z;
        5'd3:    c = CH_D;
        5'd4:    c = CH_A;
        default: c = CH_COMMA;
      endcase
      return c;
    end
  endfunction

  // hex digit value, bit 4 set for a non-hex character
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    begin
      if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
      else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
      else v = 5'd16;
      return v;
    end
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mo);
    logic [4:0] l;
    begin
      case (mo)
        4'd2:                      l = 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
        default:                   l = 5'd31;
      endcase
      return l;
    end
  endfunction

  // (153*m+2)/5 for March-based month index m
  function automatic logic [8:0] month_days(input logic [3:0] m);
    logic [8:0] d;
    begin
      case (m)
        4'd0:    d = 9'd0;
        4'd1:    d = 9'd31;
        4'd2:    d = 9'd61;
        4'd3:    d = 9'd92;
        4'd4:    d = 9'd122;
        4'd5:    d = 9'd153;
        4'd6:    d = 9'd184;
        4'd7:    d = 9'd214;
        4'd8:    d = 9'd245;
        4'd9:    d = 9'd275;
        4'd10:   d = 9'd306;
        default: d = 9'd337;
      endcase
      return d;
    end
  endfunction

  // floor(x/100) for x below 43699
  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [26:0] p;
    begin
      p = 27'(x) * 27'd5243;
      return p[26:19];
    end
  endfunction

endpackage

// ----- sv/zda_if.sv -----
// Valid/ready channel interfaces for the ZDA parser input bytes and results.
// No dependencies.
interface zda_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface zda_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;
  logic [9:0]         millisecond;
  logic [4:0]         day_of_month;
  logic [3:0]         month_number;
  logic [13:0]        year_number;
  logic signed [38:0] epoch_seconds;
  logic [29:0]        nanoseconds;
  logic [7:0]         received_checksum;
  logic [7:0]         computed_checksum;
  modport source (output valid, output status, output hour, output minute, output second,
                  output millisecond, output day_of_month, output month_number,
                  output year_number, output epoch_seconds, output nanoseconds,
                  output received_checksum, output computed_checksum, input ready);
  modport sink (input valid, input status, input hour, input minute, input second,
                input millisecond, input day_of_month, input month_number,
                input year_number, input epoch_seconds, input nanoseconds,
                input received_checksum, input computed_checksum, output ready);
endinterface

// ----- sv/nmea_zda_time_sentence_parser_core.sv -----
// NMEA ZDA sentence parser core: byte framing, field parse, epoch pipeline.
// Depends on zda_pkg and the channel interfaces in zda_if.sv.
//
// Takes one byte per cycle on in_bus and gives one result beat per sentence
// on out_bus; the edge that takes the terminating LF loads the finish stage
// with that beat, which then passes a division stage, a day-count stage and
// the output register that holds the epoch product. The byte stream is
// parsed on the fly, so the sustained rate is one byte per cycle; in_bus stalls
// only when all three finish stages and the output register are full behind a
// stalled out_bus.
module nmea_zda_time_sentence_parser_core (
  input  logic      clk,
  input  logic      rst_n,
  zda_in_if.sink    in_bus,
  zda_out_if.source out_bus
);

  typedef enum logic [2:0] {
    FR_IDLE, FR_DOLLAR, FR_BODY, FR_HEX1, FR_HEX2, FR_END, FR_LF
  } frame_t;

  localparam logic [4:0] FP_HDR_END = 5'd5;
  localparam logic [4:0] FP_TIME    = 5'd6;
  localparam logic [4:0] FP_TSEP    = 5'd7;
  localparam logic [4:0] FP_FRAC0   = 5'd8;
  localparam logic [4:0] FP_FRAC    = 5'd9;
  localparam logic [4:0] FP_DAY     = 5'd10;
  localparam logic [4:0] FP_DSEP    = 5'd11;
  localparam logic [4:0] FP_MON     = 5'd12;
  localparam logic [4:0] FP_MSEP    = 5'd13;
  localparam logic [4:0] FP_YEAR    = 5'd14;
  localparam logic [4:0] FP_DONE    = 5'd15;

  frame_t            frame_r, frame_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [zda_pkg::LenW-1:0] len_r, len_nxt;
  logic [7:0]        hexh_r, hexh_nxt, hexl_r, hexl_nxt;
  logic [4:0]        fp_r, fp_nxt;
  logic [2:0]        dc_r, dc_nxt;
  logic              bad_r, bad_nxt;
  logic [4:0]        hr_r, hr_nxt;
  logic [5:0]        mi_r, mi_nxt, se_r, se_nxt;
  logic [9:0]        ms_r, ms_nxt;
  logic [4:0]        dy_r, dy_nxt;
  logic [3:0]        mo_r, mo_nxt;
  logic [13:0]       yr_r, yr_nxt;

  logic              fin;
  zda_pkg::raw_t     fin_raw;

  logic [7:0] b;
  logic       dig;
  logic [3:0] d;
  logic [9:0] v;
  logic [13:0] ms_t;
  logic       do_body, clr;
  logic [4:0] h1, h2;

  assign b   = in_bus.rx_byte;
  assign dig = (b >= 8'h30) && (b <= 8'h39);
  assign d   = dig ? 4'(b - 8'h30) : 4'd0;

  always_comb begin
    frame_nxt = frame_r;
    xor_nxt = xor_r;
    len_nxt = len_r;
    hexh_nxt = hexh_r;
    hexl_nxt = hexl_r;
    fp_nxt = fp_r;
    dc_nxt = dc_r;
    bad_nxt = bad_r;
    hr_nxt = hr_r;
    mi_nxt = mi_r;
    se_nxt = se_r;
    ms_nxt = ms_r;
    dy_nxt = dy_r;
    mo_nxt = mo_r;
    yr_nxt = yr_r;
    fin = 1'b0;
    do_body = 1'b0;
    clr = 1'b0;
    v = '0;
    ms_t = '0;

    unique case (frame_r)
      FR_IDLE: begin
        if (b == zda_pkg::CH_DOLLAR) clr = 1'b1;
      end
      FR_DOLLAR: begin
        if (b == zda_pkg::CH_G) begin
          frame_nxt = FR_BODY;
          do_body = 1'b1;
        end else clr = 1'b1;
      end
      FR_BODY: begin
        if (b == zda_pkg::CH_STAR && len_r >= zda_pkg::LenW'(3)) frame_nxt = FR_HEX1;
        else do_body = 1'b1;
      end
      FR_HEX1: begin
        hexh_nxt = b;
        frame_nxt = FR_HEX2;
      end
      FR_HEX2: begin
        hexl_nxt = b;
        frame_nxt = FR_END;
      end
      FR_END, FR_LF: begin
        if (b == zda_pkg::CH_LF) begin
          fin = 1'b1;
          clr = 1'b1;
        end else if (b == zda_pkg::CH_CR && frame_r == FR_END) frame_nxt = FR_LF;
        else clr = 1'b1;
      end
      default: clr = 1'b1;
    endcase

    if (do_body) begin
      if (b < 8'h20 || b > 8'h7E || len_r >= zda_pkg::LenW'(zda_pkg::MaxBodyBytes)) begin
        clr = 1'b1;
      end else begin
        len_nxt = len_r + 1'b1;
        xor_nxt = xor_r ^ b;
        if (!bad_r && fp_r != FP_DONE) begin
          if (fp_r <= FP_HDR_END) begin
            if (fp_r != 5'd1 && b != zda_pkg::hdr_char(fp_r)) bad_nxt = 1'b1;
            else fp_nxt = fp_r + 1'b1;
          end else begin
            case (fp_r)
              FP_TIME: begin
                if (!dig) bad_nxt = 1'b1;
                else begin
                  if (dc_r < 3'd2) begin
                    v = 10'(hr_r) * 10'd10 + 10'(d);
                    if (dc_r == 3'd0) hr_nxt = 5'(d);
                    else if (v > 10'd23) bad_nxt = 1'b1;
                    else hr_nxt = v[4:0];
                  end else if (dc_r < 3'd4) begin
                    v = 10'(mi_r) * 10'd10 + 10'(d);
                    if (dc_r == 3'd2) mi_nxt = 6'(d);
                    else if (v > 10'd59) bad_nxt = 1'b1;
                    else mi_nxt = v[5:0];
                  end else begin
                    v = 10'(se_r) * 10'd10 + 10'(d);
                    if (dc_r == 3'd4) se_nxt = 6'(d);
                    else if (v > 10'd59) bad_nxt = 1'b1;
                    else se_nxt = v[5:0];
                  end
                  if (dc_r == 3'd5) begin
                    dc_nxt = '0;
                    fp_nxt = FP_TSEP;
                  end else dc_nxt = dc_r + 1'b1;
                end
              end
              FP_TSEP: begin
                if (b == zda_pkg::CH_DOT) fp_nxt = FP_FRAC0;
                else if (b == zda_pkg::CH_COMMA) fp_nxt = FP_DAY;
                else bad_nxt = 1'b1;
              end
              FP_FRAC0, FP_FRAC: begin
                if (dig) begin
                  ms_t = 14'(ms_r) * 14'd10 + 14'(d);
                  ms_nxt = (ms_t > 14'd999) ? 10'd999 : ms_t[9:0];
                  fp_nxt = FP_FRAC;
                end else if (fp_r == FP_FRAC && b == zda_pkg::CH_COMMA) fp_nxt = FP_DAY;
                else bad_nxt = 1'b1;
              end
              FP_DAY, FP_MON: begin
                if (!dig) bad_nxt = 1'b1;
                else begin
                  if (fp_r == FP_DAY) begin
                    v = 10'(dy_r) * 10'd10 + 10'(d);
                    if (dc_r == 3'd0) dy_nxt = 5'(d);
                    else if (v < 10'd1 || v > 10'd31) bad_nxt = 1'b1;
                    else dy_nxt = v[4:0];
                  end else begin
                    v = 10'(mo_r) * 10'd10 + 10'(d);
                    if (dc_r == 3'd0) mo_nxt = 4'(d);
                    else if (v < 10'd1 || v > 10'd12) bad_nxt = 1'b1;
                    else mo_nxt = v[3:0];
                  end
                  if (dc_r == 3'd1) begin
                    dc_nxt = '0;
                    fp_nxt = fp_r + 1'b1;
                  end else dc_nxt = dc_r + 1'b1;
                end
              end
              FP_DSEP, FP_MSEP: begin
                if (b == zda_pkg::CH_COMMA) fp_nxt = fp_r + 1'b1;
                else bad_nxt = 1'b1;
              end
              FP_YEAR: begin
                if (!dig) bad_nxt = 1'b1;
                else begin
                  yr_nxt = 14'(yr_r * 14'd10 + 14'(d));
                  if (dc_r == 3'd3) begin
                    dc_nxt = '0;
                    fp_nxt = FP_DONE;
                  end else dc_nxt = dc_r + 1'b1;
                end
              end
              default: bad_nxt = 1'b1;
            endcase
          end
        end
      end
    end

    if (clr) begin
      frame_nxt = (frame_r == FR_IDLE) ? FR_DOLLAR : FR_IDLE;
      xor_nxt = '0;
      len_nxt = '0;
      hexh_nxt = '0;
      hexl_nxt = '0;
      fp_nxt = '0;
      dc_nxt = '0;
      bad_nxt = 1'b0;
      hr_nxt = '0;
      mi_nxt = '0;
      se_nxt = '0;
      ms_nxt = '0;
      dy_nxt = '0;
      mo_nxt = '0;
      yr_nxt = '0;
    end
  end

  // end-of-sentence verdict, before the day-of-month limit check
  assign h1 = zda_pkg::hex_val(hexh_r);
  assign h2 = zda_pkg::hex_val(hexl_r);

  always_comb begin
    fin_raw.hour = hr_r;
    fin_raw.minute = mi_r;
    fin_raw.second = se_r;
    fin_raw.millisecond = ms_r;
    fin_raw.day = dy_r;
    fin_raw.month = mo_r;
    fin_raw.year = yr_r;
    fin_raw.calc_csum = xor_r;
    fin_raw.rx_csum = {h1[3:0], h2[3:0]};
    if (h1[4] || h2[4]) begin
      fin_raw.rx_csum = '0;
      fin_raw.status = zda_pkg::ST_CSUM;
    end else if (fin_raw.rx_csum != xor_r) fin_raw.status = zda_pkg::ST_CSUM;
    else if (bad_r || fp_r != FP_DONE) fin_raw.status = zda_pkg::ST_FORMAT;
    else fin_raw.status = zda_pkg::ST_OK;
  end

  // finish pipeline: s1 raw, s2 divisions, s3 day count, out register
  zda_pkg::raw_t s1_r, s2_r, s3_r;
  logic          v1_r, v2_r, v3_r, vo_r;
  logic          rdy1, rdy2, rdy3, rdyo;
  logic          acc;
  logic [13:0]   yy2_r;
  logic [7:0]    qy2_r, qr2_r;
  logic [3:0]    mm2_r;
  logic signed [23:0] days3_r;
  logic [16:0]   hms3_r;

  logic [13:0] yy_c;
  logic [3:0]  mm_c;
  logic [13:0] rem100;
  logic        leap;
  logic [4:0]  lim;
  logic signed [23:0] days_c;
  logic signed [40:0] ep_c;
  zda_pkg::raw_t s3_c;

  assign rdyo = !vo_r || out_bus.ready;
  assign rdy3 = !v3_r || rdyo;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_bus.ready = rdy1;
  assign acc = in_bus.valid && rdy1;

  assign yy_c = 14'(s1_r.year + 14'd400 - ((s1_r.month <= 4'd2) ? 14'd1 : 14'd0));
  assign mm_c = (s1_r.month <= 4'd2) ? 4'(s1_r.month + 4'd9) : 4'(s1_r.month - 4'd3);

  assign rem100 = s2_r.year - 14'(qr2_r) * 14'd100;
  assign leap = (s2_r.year[1:0] == 2'd0 && rem100 != 14'd0) ||
                (rem100 == 14'd0 && qr2_r[1:0] == 2'd0);
  assign lim = zda_pkg::month_len(s2_r.month) +
               ((s2_r.month == 4'd2 && leap) ? 5'd1 : 5'd0);
  assign days_c = 24'sd365 * $signed({10'd0, yy2_r}) + $signed({12'd0, yy2_r[13:2]})
                - $signed({16'd0, qy2_r}) + $signed({18'd0, qy2_r[7:2]})
                + $signed({15'd0, zda_pkg::month_days(mm2_r)}) + $signed({19'd0, s2_r.day})
                - 24'sd865566;

  always_comb begin
    s3_c = s2_r;
    if (s2_r.status == zda_pkg::ST_OK && s2_r.day > lim) s3_c.status = zda_pkg::ST_FORMAT;
  end

  assign ep_c = 41'(days3_r) * 41'sd86400 + $signed({24'd0, hms3_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= FR_IDLE;
      xor_r <= '0;
      len_r <= '0;
      hexh_r <= '0;
      hexl_r <= '0;
      fp_r <= '0;
      dc_r <= '0;
      bad_r <= 1'b0;
      hr_r <= '0;
      mi_r <= '0;
      se_r <= '0;
      ms_r <= '0;
      dy_r <= '0;
      mo_r <= '0;
      yr_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (acc) begin
        frame_r <= frame_nxt;
        xor_r <= xor_nxt;
        len_r <= len_nxt;
        hexh_r <= hexh_nxt;
        hexl_r <= hexl_nxt;
        fp_r <= fp_nxt;
        dc_r <= dc_nxt;
        bad_r <= bad_nxt;
        hr_r <= hr_nxt;
        mi_r <= mi_nxt;
        se_r <= se_nxt;
        ms_r <= ms_nxt;
        dy_r <= dy_nxt;
        mo_r <= mo_nxt;
        yr_r <= yr_nxt;
      end
      if (rdy1) v1_r <= acc && fin;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdyo) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= fin_raw;
    if (rdy2) begin
      s2_r <= s1_r;
      yy2_r <= yy_c;
      mm2_r <= mm_c;
      qy2_r <= zda_pkg::div100(yy_c);
      qr2_r <= zda_pkg::div100(s1_r.year);
    end
    if (rdy3) begin
      s3_r <= s3_c;
      days3_r <= days_c;
      hms3_r <= 17'(s2_r.hour) * 17'd3600 + 17'(s2_r.minute) * 17'd60 + 17'(s2_r.second);
    end
    if (rdyo) begin
      out_bus.status <= s3_r.status;
      out_bus.received_checksum <= s3_r.rx_csum;
      out_bus.computed_checksum <= s3_r.calc_csum;
      if (s3_r.status == zda_pkg::ST_OK) begin
        out_bus.hour <= s3_r.hour;
        out_bus.minute <= s3_r.minute;
        out_bus.second <= s3_r.second;
        out_bus.millisecond <= s3_r.millisecond;
        out_bus.day_of_month <= s3_r.day;
        out_bus.month_number <= s3_r.month;
        out_bus.year_number <= s3_r.year;
        out_bus.epoch_seconds <= ep_c[38:0];
        out_bus.nanoseconds <= 30'(s3_r.millisecond) * 30'd1000000;
      end else begin
        out_bus.hour <= '0;
        out_bus.minute <= '0;
        out_bus.second <= '0;
        out_bus.millisecond <= '0;
        out_bus.day_of_month <= '0;
        out_bus.month_number <= '0;
        out_bus.year_number <= '0;
        out_bus.epoch_seconds <= '0;
        out_bus.nanoseconds <= '0;
      end
    end
  end

  assign out_bus.valid = vo_r;

endmodule

// ----- sv/zda_checker.sv -----
// Port-level assertions for the ZDA parser core, bound to the core module.
// Depends on zda_pkg and nmea_zda_time_sentence_parser_core.
module zda_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second,
  input logic [29:0] nanoseconds
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(nanoseconds))
    else $error("result beat dropped or changed under stall");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status != zda_pkg::ST_RSVD)
    else $error("undefined status");

  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == zda_pkg::ST_OK |-> hour <= 5'd23 && minute <= 6'd59 &&
      second <= 6'd59 && nanoseconds <= 30'd999000000)
    else $error("ok result with out-of-range time");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != zda_pkg::ST_OK |-> hour == 5'd0 && nanoseconds == 30'd0)
    else $error("error result carries time fields");

endmodule

bind nmea_zda_time_sentence_parser_core zda_checker u_zda_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .status(out_bus.status),
  .hour(out_bus.hour),
  .minute(out_bus.minute),
  .second(out_bus.second),
  .nanoseconds(out_bus.nanoseconds)
);
